FILE: design/rml_pkg.sv
// ----------------------------------------------------------------------------
// rml_pkg: shared types and constants for the record member layout block
// Word layouts for the member and result items and the storage unit size
// used for bit-field packing.
// ----------------------------------------------------------------------------
package rml_pkg;

	// Default width of the running offset registers
	localparam int OFFSET_BITS_DEF = 16;

	// Bit-field storage unit, must be a power of two
	localparam int UNIT_BYTES = 4;
	localparam int UNIT_NBITS = UNIT_BYTES * 8;

	// Field widths of the member and result words
	localparam int SIZE_W  = 16;
	localparam int ALIGN_W = 13;
	localparam int FBITS_W = 6;
	localparam int BOFF_W  = 5;

	// Stream word widths
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 1;

	// One member description
	typedef struct packed {
		logic [SIZE_W-1:0]  member_size;
		logic [ALIGN_W-1:0] member_align;
		logic               bitfield_flag;
		logic [FBITS_W-1:0] field_bits;
		logic               is_union;
		logic               last_member;
	} item_t;

	// One layout result
	typedef struct packed {
		logic [SIZE_W-1:0]  member_offset;
		logic [BOFF_W-1:0]  member_bit_offset;
		logic [SIZE_W-1:0]  record_size;
		logic [ALIGN_W-1:0] record_align;
		logic               record_done;
		logic               overflow;
	} result_t;

endpackage

FILE: design/rml_align_norm.sv
// ----------------------------------------------------------------------------
// rml_align_norm: alignment normalizer
// Maps a raw alignment to a power of two: zero becomes one, anything else
// keeps only its highest set bit.
// ----------------------------------------------------------------------------
module rml_align_norm (
	input  logic [rml_pkg::ALIGN_W-1:0] align_raw,
	output logic [rml_pkg::ALIGN_W-1:0] align_norm
);

	// Keep the highest set bit, default to one
	always_comb begin
		align_norm = rml_pkg::ALIGN_W'(1);
		for (int i = 0; i < rml_pkg::ALIGN_W; i++) begin
			if (align_raw[i]) begin
				align_norm = rml_pkg::ALIGN_W'(1) << i;
			end
		end
	end

endmodule

FILE: design/rml_layout_core.sv
// ----------------------------------------------------------------------------
// rml_layout_core: member placement logic and running layout state
// Places one member per adv cycle against running offset, bit-field unit and
// union width registers, and clears the state after the last member.
// ----------------------------------------------------------------------------
module rml_layout_core #(
	parameter int OFFSET_BITS = rml_pkg::OFFSET_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  rml_pkg::item_t   item,
	output rml_pkg::result_t result
);

	// Work width covers offset plus a full member size or alignment pad
	localparam int W = ((OFFSET_BITS > rml_pkg::SIZE_W) ? OFFSET_BITS : rml_pkg::SIZE_W) + 2;
	localparam logic [W-1:0] OMAX = {{(W-OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};
	localparam logic [W-1:0] UBW  = W'(rml_pkg::UNIT_BYTES);
	localparam logic [rml_pkg::FBITS_W-1:0] UBITS = rml_pkg::FBITS_W'(rml_pkg::UNIT_NBITS);
	localparam logic [rml_pkg::ALIGN_W-1:0] UALIGN = rml_pkg::ALIGN_W'(rml_pkg::UNIT_BYTES);

	// Running state
	logic [OFFSET_BITS-1:0]      run_q;
	logic [OFFSET_BITS-1:0]      ustart_q;
	logic [OFFSET_BITS-1:0]      widest_q;
	logic [rml_pkg::ALIGN_W-1:0] salign_q;
	logic [rml_pkg::FBITS_W-1:0] ubits_q;
	logic                        uopen_q;
	logic                        ovf_q;

	// Next state
	logic [W-1:0]                run_d;
	logic [W-1:0]                ust_d;
	logic [W-1:0]                wid_d;
	logic [rml_pkg::ALIGN_W-1:0] sal_d;
	logic [rml_pkg::FBITS_W-1:0] ub_d;
	logic                        uo_d;
	logic                        ovf_d;

	// Result pieces
	logic [W-1:0]                off;
	logic [W-1:0]                rsize;
	logic [W-1:0]                endv;
	logic [W-1:0]                t;
	logic [rml_pkg::FBITS_W-1:0] boff;
	logic [rml_pkg::FBITS_W-1:0] wb;
	logic [rml_pkg::ALIGN_W-1:0] ralign;

	// Saturate to the offset range
	function automatic logic [W-1:0] sat(input logic [W-1:0] v);
		return (v > OMAX) ? OMAX : v;
	endfunction

	// Round up to a power-of-two alignment
	function automatic logic [W-1:0] rup(input logic [W-1:0] v,
			input logic [rml_pkg::ALIGN_W-1:0] a);
		logic [W-1:0] m;
		m = W'(a) - W'(1);
		return (v + m) & ~m;
	endfunction

	// Place the member
	always_comb begin
		run_d  = W'(run_q);
		ust_d  = W'(ustart_q);
		wid_d  = W'(widest_q);
		sal_d  = salign_q;
		ub_d   = ubits_q;
		uo_d   = uopen_q;
		ovf_d  = ovf_q;
		off    = '0;
		boff   = '0;
		rsize  = '0;
		ralign = '0;
		endv   = '0;
		t      = '0;
		wb     = (item.field_bits > UBITS) ? UBITS : item.field_bits;

		if (item.is_union) begin
			// Union: everything at zero, track widest member
			t = item.bitfield_flag ? UBW : W'(item.member_size);
			if (t > OMAX) ovf_d = 1'b1;
			t = sat(t);
			if (item.member_align > sal_d) sal_d = item.member_align;
			if (t > wid_d) wid_d = t;
		end else if (item.bitfield_flag) begin
			if (wb == '0) begin
				// Zero width: close the open unit
				if (ub_d != '0) begin
					t = ust_d + UBW;
					if (t > OMAX) ovf_d = 1'b1;
					run_d = sat(t);
				end
				ub_d = '0;
				uo_d = 1'b0;
			end else begin
				// Open a new unit when none is open or the field does not fit
				if (!uo_d || ({1'b0, ub_d} + {1'b0, wb}) > {1'b0, UBITS}) begin
					if (ub_d != '0) begin
						t = ust_d + UBW;
						if (t > OMAX) ovf_d = 1'b1;
						run_d = sat(t);
					end
					ub_d = '0;
					t = rup(run_d, UALIGN);
					if (t > OMAX) ovf_d = 1'b1;
					ust_d = sat(t);
					run_d = ust_d;
					uo_d  = 1'b1;
				end
				off  = ust_d;
				boff = ub_d;
				ub_d = ub_d + wb;
				if (UALIGN > sal_d) sal_d = UALIGN;
			end
		end else begin
			// Plain member: close unit, align, advance
			if (ub_d != '0) begin
				t = ust_d + UBW;
				if (t > OMAX) ovf_d = 1'b1;
				run_d = sat(t);
			end
			ub_d = '0;
			uo_d = 1'b0;
			if (item.member_align > sal_d) sal_d = item.member_align;
			t = rup(run_d, item.member_align);
			if (t > OMAX) ovf_d = 1'b1;
			run_d = sat(t);
			off = run_d;
			t = run_d + W'(item.member_size);
			if (t > OMAX) ovf_d = 1'b1;
			run_d = sat(t);
		end

		// Finish the record on the last member
		if (item.last_member) begin
			if (item.is_union) begin
				endv = wid_d;
			end else begin
				if (ub_d != '0) begin
					t = ust_d + UBW;
					if (t > OMAX) ovf_d = 1'b1;
					run_d = sat(t);
				end
				endv = run_d;
			end
			ralign = sal_d;
			if (endv != '0) begin
				t = rup(endv, sal_d);
				if (t > OMAX) ovf_d = 1'b1;
				rsize = sat(t);
			end
		end
	end

	// Drive the result
	always_comb begin
		result.member_offset     = off[rml_pkg::SIZE_W-1:0];
		result.member_bit_offset = boff[rml_pkg::BOFF_W-1:0];
		result.record_size       = rsize[rml_pkg::SIZE_W-1:0];
		result.record_align      = ralign;
		result.record_done       = item.last_member;
		result.overflow          = ovf_d;
	end

	// Update state, clear after the last member
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= '0;
			ustart_q <= '0;
			widest_q <= '0;
			salign_q <= rml_pkg::ALIGN_W'(1);
			ubits_q  <= '0;
			uopen_q  <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (adv) begin
			if (item.last_member) begin
				run_q    <= '0;
				ustart_q <= '0;
				widest_q <= '0;
				salign_q <= rml_pkg::ALIGN_W'(1);
				ubits_q  <= '0;
				uopen_q  <= 1'b0;
				ovf_q    <= 1'b0;
			end else begin
				run_q    <= run_d[OFFSET_BITS-1:0];
				ustart_q <= ust_d[OFFSET_BITS-1:0];
				widest_q <= wid_d[OFFSET_BITS-1:0];
				salign_q <= sal_d;
				ubits_q  <= ub_d;
				uopen_q  <= uo_d;
				ovf_q    <= ovf_d;
			end
		end
	end

endmodule

FILE: design/record_member_layout_top.sv
// ----------------------------------------------------------------------------
// record_member_layout_top: struct and union member layout engine
// Input stage, placement logic and output register for one record at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the members of a record in declaration order on the s_ channel, one
//   word per member, with s_tlast on the final member. Each member yields one
//   result word on the m_ channel carrying its byte and bit offset; the word
//   for the final member has m_tlast set and also carries the padded record
//   size and alignment. m_tuser flags an offset overflow within the record.
//   An accepted member passes the input register, then the result register,
//   before its result word appears. Throughput is one member per cycle while
//   m_tready holds no result back: the placement logic is combinational against
//   the running offset registers, so members may follow back to back.
//   Reset clears both stages and the running layout state, so the first
//   member after reset starts a new record at offset zero.
//   When m_tready is low the result register holds; the input register takes
//   one more word if empty, after which s_tready drops until the result drains.
// ----------------------------------------------------------------------------
module record_member_layout_top #(
	parameter int OFFSET_BITS = rml_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// member_size[15:0], member_align[28:16], field_bits[34:29], zero fill
	input  logic [rml_pkg::IN_DATA_W-1:0]  s_tdata,
	// bitfield_flag[0], is_union[1]
	input  logic [rml_pkg::IN_USER_W-1:0]  s_tuser,
	input  logic                           s_tlast,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// member_offset[15:0], member_bit_offset[20:16], record_size[36:21],
	// record_align[49:37], zero fill
	output logic [rml_pkg::OUT_DATA_W-1:0] m_tdata,
	// overflow[0]
	output logic [rml_pkg::OUT_USER_W-1:0] m_tuser,
	output logic                           m_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready
);

	logic                        valid_s1;
	logic                        valid_s2;
	rml_pkg::item_t              item_s1;
	rml_pkg::item_t              item_in;
	rml_pkg::result_t            res_s2;
	rml_pkg::result_t            res_d;
	logic [rml_pkg::ALIGN_W-1:0] align_norm;
	logic                        load_s2;
	logic                        adv;

	// Normalize the alignment ahead of the input register
	rml_align_norm u_align (
		.align_raw  (s_tdata[28:16]),
		.align_norm (align_norm)
	);

	// Unpack the input word
	always_comb begin
		item_in.member_size   = s_tdata[15:0];
		item_in.member_align  = align_norm;
		item_in.bitfield_flag = s_tuser[0];
		item_in.field_bits    = s_tdata[34:29];
		item_in.is_union      = s_tuser[1];
		item_in.last_member   = s_tlast;
	end

	// Stage handshake
	assign load_s2  = !valid_s2 || m_tready;
	assign adv      = valid_s1 && load_s2;
	assign s_tready = !valid_s1 || load_s2;

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) item_s1 <= item_in;
		if (adv) res_s2 <= res_d;
	end

	// Placement logic and running state
	rml_layout_core #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.result (res_d)
	);

	// Pack the result word
	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.record_done;
	assign m_tuser  = res_s2.overflow;
	assign m_tdata  = {6'b0, res_s2.record_align, res_s2.record_size,
		res_s2.member_bit_offset, res_s2.member_offset};

endmodule
